>>> design/vdu_pkg.sv
// Shared types, constants and arithmetic helpers for the vector distance unit.
`default_nettype none
package vdu_pkg;

  localparam int SUM_W          = 48;
  localparam int MAX_DIM_DEF    = 1024;
  localparam int ELEM_WIDTH_DEF = 16;
  localparam int QUEUE_DEPTH    = 2;
  localparam int WIDE_W         = 66;

  localparam logic [1:0] MODE_L1     = 2'd0;
  localparam logic [1:0] MODE_L2     = 2'd1;
  localparam logic [1:0] MODE_COSINE = 2'd2;
  localparam logic [1:0] MODE_INNER  = 2'd3;

  typedef logic [1:0] mode_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  typedef struct packed {
    mode_t mode;
    sum_t  psum;
    sum_t  nxsum;
    sum_t  nysum;
  } vdu_entry_t;

  function automatic sum_t sat48(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    begin
      hi = (WIDE_W'(signed'(1)) <<< (SUM_W-1)) - WIDE_W'(signed'(1));
      lo = -(hi + WIDE_W'(signed'(1)));
      if (v > hi) begin
        sat48 = {1'b0, {(SUM_W-1){1'b1}}};
      end else if (v < lo) begin
        sat48 = {1'b1, {(SUM_W-1){1'b0}}};
      end else begin
        sat48 = v[SUM_W-1:0];
      end
    end
  endfunction

endpackage
`default_nettype wire

>>> design/vector_distance_unit.sv
// Top level of the vector distance unit.
// The unit takes one x/y element pair per cycle on the slave stream while
// s_tready is high; the pair with tlast closes the vectors. Sums of L1/L2/dot
// terms and both squared norms are kept by a two-stage front end and handed to
// a two-entry queue, so streaming continues while earlier vectors finish. The
// back end turns a closed vector into one 48-bit Q31.16 distance: L1 and inner
// product are only scaled, L2 takes one 32-step bit-serial square root, cosine
// with nonzero norms two square roots, one 32x32 multiply and a 64-step
// restoring divide. The mode register sits at address 0 of the APB port.
`default_nettype none
module vector_distance_unit #(
  parameter int MAX_DIM    = vdu_pkg::MAX_DIM_DEF,
  parameter int ELEM_WIDTH = vdu_pkg::ELEM_WIDTH_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    s_tvalid,
  output logic                         s_tready,
  input  wire logic [2*ELEM_WIDTH-1:0] s_tdata,  // x_elem, y_elem
  input  wire logic                    s_tlast,  // last_elem
  output logic                         m_tvalid,
  input  wire logic                    m_tready,
  output logic [47:0]                  m_tdata,  // distance_value
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [2:0]              paddr,
  input  wire logic [31:0]             pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import vdu_pkg::*;

  mode_t      metric_mode;
  logic       push;
  logic       pop;
  logic       q_empty;
  vdu_entry_t push_data;
  vdu_entry_t pop_data;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;
  sum_t       out_value;

  assign pready  = 1'b1;
  assign prdata  = (paddr[2] == 1'b0) ? {30'd0, metric_mode} : 32'd0;
  assign m_tdata = out_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      metric_mode <= MODE_L1;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      metric_mode <= pwdata[1:0];
    end
  end

  vdu_front #(.MAX_DIM(MAX_DIM), .ELEM_WIDTH(ELEM_WIDTH)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready),
    .x_elem(s_tdata[ELEM_WIDTH-1:0]), .y_elem(s_tdata[2*ELEM_WIDTH-1:ELEM_WIDTH]),
    .last_elem(s_tlast), .metric_mode(metric_mode), .q_count(q_count),
    .push(push), .push_data(push_data)
  );

  vdu_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_data(push_data),
    .pop(pop), .pop_data(pop_data), .empty(q_empty), .count(q_count)
  );

  vdu_back u_back (
    .clk(clk), .rst(rst), .q_empty(q_empty), .q_data(pop_data), .pop(pop),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_value(out_value)
  );
endmodule
`default_nettype wire

>>> design/vdu_queue.sv
// Small FIFO of closed vector sums between front and back.
`default_nettype none
module vdu_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire vdu_pkg::vdu_entry_t push_data,
  input  wire logic               pop,
  output vdu_pkg::vdu_entry_t     pop_data,
  output logic                    empty,
  output logic [$clog2(vdu_pkg::QUEUE_DEPTH+1)-1:0] count
);
  import vdu_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  vdu_entry_t     store [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;

  assign empty    = (count == '0);
  assign pop_data = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
    end
  end
endmodule
`default_nettype wire

>>> design/vdu_front.sv
// Front end: accepts element pairs, forms terms, accumulates saturating sums.
`default_nettype none
module vdu_front #(
  parameter int MAX_DIM    = vdu_pkg::MAX_DIM_DEF,
  parameter int ELEM_WIDTH = vdu_pkg::ELEM_WIDTH_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic signed [ELEM_WIDTH-1:0] x_elem,
  input  wire logic signed [ELEM_WIDTH-1:0] y_elem,
  input  wire logic                    last_elem,
  input  wire vdu_pkg::mode_t          metric_mode,
  input  wire logic [$clog2(vdu_pkg::QUEUE_DEPTH+1)-1:0] q_count,
  output logic                         push,
  output vdu_pkg::vdu_entry_t          push_data
);
  import vdu_pkg::*;

  localparam int CW = $clog2(MAX_DIM + 1);
  localparam int AW = ELEM_WIDTH + 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  function automatic sum_t sq_sat(input logic [AW-1:0] a);
    logic [2*AW-1:0] prod;
    begin
      prod = a * a;
      if (WIDE_W'(a) > (WIDE_W'(1) << 24)) begin
        sq_sat = {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
        sq_sat = sat48(signed'(WIDE_W'(prod)));
      end
    end
  endfunction

  logic                       accept;
  logic [CW-1:0]              count;
  logic signed [AW-1:0]       diff;
  logic [AW-1:0]              adiff;
  logic [AW-1:0]              ax;
  logic [AW-1:0]              ay;
  logic signed [2*ELEM_WIDTH-1:0] xy;
  sum_t                       term;

  logic  s1_valid;
  logic  s1_last;
  logic  s1_add;
  mode_t s1_mode;
  sum_t  s1_term;
  sum_t  s1_tx;
  sum_t  s1_ty;

  sum_t  psum;
  sum_t  nxsum;
  sum_t  nysum;
  sum_t  psum_next;
  sum_t  nxsum_next;
  sum_t  nysum_next;

  assign in_ready = (QCW'(32'(q_count) + ((s1_valid && s1_last) ? 1 : 0)) < QCW'(QUEUE_DEPTH));
  assign accept   = in_valid && in_ready;

  always_comb begin
    diff  = AW'(x_elem) - AW'(y_elem);
    adiff = diff[AW-1] ? AW'(-diff) : AW'(diff);
    ax    = x_elem[ELEM_WIDTH-1] ? AW'(-AW'(x_elem)) : AW'(x_elem);
    ay    = y_elem[ELEM_WIDTH-1] ? AW'(-AW'(y_elem)) : AW'(y_elem);
    xy    = (2*ELEM_WIDTH)'(x_elem) * (2*ELEM_WIDTH)'(y_elem);
    unique case (metric_mode)
      MODE_L1:     term = SUM_W'(adiff);
      MODE_L2:     term = sq_sat(adiff);
      default:     term = sat48(WIDE_W'(xy));
    endcase
  end

  always_comb begin
    psum_next  = sat48(WIDE_W'(psum) + WIDE_W'(s1_term));
    nxsum_next = sat48(WIDE_W'(nxsum) + WIDE_W'(s1_tx));
    nysum_next = sat48(WIDE_W'(nysum) + WIDE_W'(s1_ty));
    if (!s1_add) begin
      psum_next  = psum;
      nxsum_next = nxsum;
      nysum_next = nysum;
    end
  end

  assign push = s1_valid && s1_last;
  assign push_data = '{mode: s1_mode, psum: psum_next, nxsum: nxsum_next, nysum: nysum_next};

  always_ff @(posedge clk) begin
    s1_last <= last_elem;
    s1_mode <= metric_mode;
    s1_term <= term;
    s1_tx   <= sq_sat(ax);
    s1_ty   <= sq_sat(ay);
    s1_add  <= (count < CW'(MAX_DIM));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      count    <= '0;
      psum     <= '0;
      nxsum    <= '0;
      nysum    <= '0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        if (last_elem) begin
          count <= '0;
        end else if (count < CW'(MAX_DIM)) begin
          count <= count + 1'b1;
        end
      end
      if (s1_valid) begin
        if (s1_last) begin
          psum  <= '0;
          nxsum <= '0;
          nysum <= '0;
        end else begin
          psum  <= psum_next;
          nxsum <= nxsum_next;
          nysum <= nysum_next;
        end
      end
    end
  end
endmodule
`default_nettype wire

>>> design/vdu_back.sv
// Back end: final scaling, bit-serial square root and divide, output register.
`default_nettype none
module vdu_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                q_empty,
  input  wire vdu_pkg::vdu_entry_t q_data,
  output logic                     pop,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output vdu_pkg::sum_t            out_value
);
  import vdu_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQRT = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]  state;
  mode_t       mode;
  sum_t        psum;
  sum_t        nysum;
  sum_t        res;

  logic [63:0] sq_n;
  logic [33:0] sq_rem;
  logic [31:0] sq_root;
  logic [4:0]  sq_cnt;
  logic        sq_second;
  logic [33:0] sq_rem_sh;
  logic [33:0] sq_trial;
  logic        sq_ge;
  logic [31:0] sq_root_next;

  logic [31:0] rx;
  logic [31:0] ry;
  logic [63:0] den;
  logic [63:0] dv;
  logic [64:0] dv_rem;
  logic [63:0] quo;
  logic [5:0]  dv_cnt;
  logic [64:0] dv_rem_sh;
  logic        dv_ge;
  logic [47:0] pabs;
  logic signed [WIDE_W-1:0] qs;
  logic        load_out;

  assign pop      = (state == ST_IDLE) && !q_empty;
  assign load_out = (state == ST_FIN) && (!out_valid || out_ready);

  always_comb begin
    sq_rem_sh    = {sq_rem[31:0], sq_n[63:62]};
    sq_trial     = {sq_root, 2'b01};
    sq_ge        = (sq_rem_sh >= sq_trial);
    sq_root_next = {sq_root[30:0], sq_ge};
    dv_rem_sh    = {dv_rem[63:0], dv[63]};
    dv_ge        = (dv_rem_sh >= {1'b0, den});
    pabs         = psum[SUM_W-1] ? 48'(-psum) : 48'(psum);
    qs           = signed'(WIDE_W'({quo[62:0], dv_ge}));
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        mode   <= q_data.mode;
        psum   <= q_data.psum;
        nysum  <= q_data.nysum;
        sq_rem <= '0;
        sq_root <= '0;
        sq_cnt <= '0;
        sq_second <= 1'b0;
        if (q_data.mode == MODE_L2) begin
          sq_n <= q_data.psum[SUM_W-1] ? 64'd0 : 64'({q_data.psum, 8'd0});
        end else begin
          sq_n <= {q_data.nxsum, 16'd0};
        end
        unique case (q_data.mode)
          MODE_L1:     res <= sat48(WIDE_W'(q_data.psum) <<< 4);
          MODE_INNER:  res <= q_data.psum >>> 8;
          default:     res <= SUM_W'(131072);
        endcase
      end
      ST_SQRT: begin
        sq_n    <= {sq_n[61:0], 2'b00};
        sq_rem  <= sq_ge ? sq_rem_sh - sq_trial : sq_rem_sh;
        sq_root <= sq_root_next;
        sq_cnt  <= sq_cnt + 1'b1;
        if (sq_cnt == 5'd31) begin
          res <= SUM_W'(sq_root_next);
          if (!sq_second) begin
            rx        <= sq_root_next;
            sq_second <= 1'b1;
            sq_n      <= {nysum, 16'd0};
            sq_rem    <= '0;
            sq_root   <= '0;
          end else begin
            ry <= sq_root_next;
          end
        end
      end
      ST_MUL: begin
        den    <= rx * ry;
        dv     <= {pabs, 16'd0};
        dv_rem <= '0;
        quo    <= '0;
        dv_cnt <= '0;
      end
      ST_DIV: begin
        dv     <= {dv[62:0], 1'b0};
        dv_rem <= dv_ge ? dv_rem_sh - {1'b0, den} : dv_rem_sh;
        quo    <= {quo[62:0], dv_ge};
        dv_cnt <= dv_cnt + 1'b1;
        if (dv_cnt == 6'd63) begin
          res <= psum[SUM_W-1] ? sat48(WIDE_W'(65536) + qs) : sat48(WIDE_W'(65536) - qs);
        end
      end
      default: begin
      end
    endcase
    if (load_out) begin
      out_value <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            if (q_data.mode == MODE_L2) begin
              state <= ST_SQRT;
            end else if (q_data.mode == MODE_COSINE &&
                         q_data.nxsum > 0 && q_data.nysum > 0) begin
              state <= ST_SQRT;
            end else begin
              state <= ST_FIN;
            end
          end
        end
        ST_SQRT: begin
          if (sq_cnt == 5'd31) begin
            if (mode == MODE_L2) begin
              state <= ST_FIN;
            end else if (sq_second) begin
              state <= ST_MUL;
            end
          end
        end
        ST_MUL: state <= ST_DIV;
        ST_DIV: begin
          if (dv_cnt == 6'd63) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (load_out) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> design/vdu_checker.sv
// Port-level checks for the vector distance unit, bound to the top level.
`default_nettype none
module vdu_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [47:0] m_tdata,
  input wire logic        psel,
  input wire logic        penable,
  input wire logic        pwrite,
  input wire logic [2:0]  paddr,
  input wire logic [31:0] pwdata,
  input wire logic [31:0] prdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result dropped or changed while stalled");

  a_reset: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

  a_cfg: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && paddr[2] == 1'b0
      |=> paddr[2] != 1'b0 || prdata[1:0] == $past(pwdata[1:0]))
    else $error("mode readback mismatch");

  a_rdata: assert property (@(posedge clk) prdata[31:2] == 30'd0)
    else $error("unused read bits set");
endmodule

bind vector_distance_unit vdu_checker u_vdu_checker (
  .clk(clk), .rst(rst), .m_tvalid(m_tvalid), .m_tready(m_tready),
  .m_tdata(m_tdata), .psel(psel), .penable(penable), .pwrite(pwrite),
  .paddr(paddr), .pwdata(pwdata), .prdata(prdata)
);
`default_nettype wire
